### rtl/rcle_pkg.sv
// ----------------------------------------------------------------------------
// RV64 constant-load expander: shared package
// Item types, opcode constants, slot layout and instruction encoders used by
// the front, the queue and the back of the expander.
// ----------------------------------------------------------------------------
`default_nettype none

package rcle_pkg;

  // Base encodings of the three instructions the expander emits.
  localparam logic [31:0] OPC_LUI  = 32'h0000_0037;
  localparam logic [31:0] OPC_ADDI = 32'h0000_0013;
  localparam logic [31:0] OPC_SLLI = 32'h0000_1013;

  // Rounding bias applied before taking the upper 20 bits for lui.
  localparam logic [11:0] HALF_ROUND = 12'h800;

  // Shift amounts of the low-half pieces (11, 11 and 10 bits wide).
  localparam logic [5:0] SH_PIECE_HI  = 6'd11;
  localparam logic [5:0] SH_PIECE_MID = 6'd11;
  localparam logic [5:0] SH_PIECE_LO  = 6'd10;
  localparam logic [5:0] SH_TWO_HI    = 6'd22;
  localparam logic [5:0] SH_FULL      = 6'd32;

  // Fixed candidate positions of the instruction sequence, in emission order.
  localparam int NUM_SLOTS = 9;
  localparam int SLOT_LUI     = 0;
  localparam int SLOT_ADDI_HI = 1;
  localparam int SLOT_SLLI_0  = 2;
  localparam int SLOT_ADDI_0  = 3;
  localparam int SLOT_SLLI_1  = 4;
  localparam int SLOT_ADDI_1  = 5;
  localparam int SLOT_SLLI_2  = 6;
  localparam int SLOT_ADDI_2  = 7;
  localparam int SLOT_FLUSH   = 8;

  // Input item: constant and destination register.
  typedef struct packed {
    logic [63:0] value;
    logic [4:0]  dest_reg;
  } in_item_t;

  // Result item: one encoded instruction word.
  typedef struct packed {
    logic [31:0] insn_word;
    logic        last;
  } out_item_t;

  // Classified item: every candidate word plus the mask of words to emit.
  typedef struct packed {
    logic [NUM_SLOTS-1:0][31:0] words;
    logic [NUM_SLOTS-1:0]       mask;
  } desc_t;

  function automatic logic [31:0] enc_lui(input logic [4:0] rd, input logic [19:0] hi);
    enc_lui = OPC_LUI | {hi, 12'd0} | {20'd0, rd, 7'd0};
  endfunction

  function automatic logic [31:0] enc_addi(input logic [4:0] rd, input logic [4:0] rs1,
                                           input logic [11:0] imm);
    enc_addi = OPC_ADDI | {imm, 20'd0} | {12'd0, rs1, 15'd0} | {20'd0, rd, 7'd0};
  endfunction

  function automatic logic [31:0] enc_slli(input logic [4:0] rd, input logic [5:0] sh);
    enc_slli = OPC_SLLI | {6'd0, sh, 20'd0} | {12'd0, rd, 15'd0} | {20'd0, rd, 7'd0};
  endfunction

endpackage

`default_nettype wire

### rtl/rcle_front.sv
// ----------------------------------------------------------------------------
// RV64 constant-load expander: front end
// Classifies each accepted constant as short or long path and encodes every
// candidate instruction word together with the mask of words to emit.
// ----------------------------------------------------------------------------
`default_nettype none

module rcle_front (
  input  var rcle_pkg::in_item_t in_item,
  output var rcle_pkg::desc_t    desc
);

  logic [63:0] biased;
  logic [31:0] upper_biased;
  logic        short_path;
  logic [19:0] hi;
  logic [11:0] lo;
  logic        has_hi;
  logic [4:0]  rd;
  logic [4:0]  rs1_hi;
  logic [31:0] low_half;
  logic        p0;
  logic        p1;
  logic        p2;
  logic [5:0]  sh1;
  logic [5:0]  sh2;

  // Path choice: the short form is only correct when value+0x800 stays below 2^31.
  assign biased       = in_item.value + {52'd0, rcle_pkg::HALF_ROUND};
  assign upper_biased = in_item.value[63:32] + {20'd0, rcle_pkg::HALF_ROUND};
  assign short_path   = (biased[63:31] == 33'd0);

  // Upper/lower split for the lui/addi pair of either path.
  assign hi     = short_path ? biased[31:12] : upper_biased[31:12];
  assign lo     = short_path ? in_item.value[11:0] : in_item.value[43:32];
  assign has_hi = (hi != 20'd0);
  assign rd     = in_item.dest_reg;
  assign rs1_hi = has_hi ? rd : 5'd0;

  // Piece presence of the low half; a missing piece carries its shift forward.
  assign low_half = in_item.value[31:0];
  assign p0       = (low_half[31:21] != 11'd0);
  assign p1       = (low_half[31:10] != 22'd0);
  assign p2       = (low_half != 32'd0);
  assign sh1      = p0 ? rcle_pkg::SH_PIECE_MID : rcle_pkg::SH_TWO_HI;
  assign sh2      = p1 ? rcle_pkg::SH_PIECE_LO : rcle_pkg::SH_FULL;

  // Candidate words and emission mask.
  always_comb begin
    desc = '0;
    desc.words[rcle_pkg::SLOT_LUI]     = rcle_pkg::enc_lui(rd, hi);
    desc.words[rcle_pkg::SLOT_ADDI_HI] = rcle_pkg::enc_addi(rd, rs1_hi, lo);
    desc.words[rcle_pkg::SLOT_SLLI_0]  = rcle_pkg::enc_slli(rd, rcle_pkg::SH_PIECE_HI);
    desc.words[rcle_pkg::SLOT_ADDI_0]  = rcle_pkg::enc_addi(rd, rd, {1'b0, low_half[31:21]});
    desc.words[rcle_pkg::SLOT_SLLI_1]  = rcle_pkg::enc_slli(rd, sh1);
    desc.words[rcle_pkg::SLOT_ADDI_1]  = rcle_pkg::enc_addi(rd, rd, {1'b0, low_half[20:10]});
    desc.words[rcle_pkg::SLOT_SLLI_2]  = rcle_pkg::enc_slli(rd, sh2);
    desc.words[rcle_pkg::SLOT_ADDI_2]  = rcle_pkg::enc_addi(rd, rd, {2'b0, low_half[9:0]});
    desc.words[rcle_pkg::SLOT_FLUSH]   = rcle_pkg::enc_slli(rd, rcle_pkg::SH_FULL);

    desc.mask[rcle_pkg::SLOT_LUI]     = has_hi;
    desc.mask[rcle_pkg::SLOT_ADDI_HI] = !has_hi || (lo != 12'd0);
    desc.mask[rcle_pkg::SLOT_SLLI_0]  = !short_path && p0;
    desc.mask[rcle_pkg::SLOT_ADDI_0]  = !short_path && p0;
    desc.mask[rcle_pkg::SLOT_SLLI_1]  = !short_path && p1;
    desc.mask[rcle_pkg::SLOT_ADDI_1]  = !short_path && p1;
    desc.mask[rcle_pkg::SLOT_SLLI_2]  = !short_path && p2;
    desc.mask[rcle_pkg::SLOT_ADDI_2]  = !short_path && p2;
    desc.mask[rcle_pkg::SLOT_FLUSH]   = !short_path && !p2;
  end

endmodule

`default_nettype wire

### rtl/rcle_queue.sv
// ----------------------------------------------------------------------------
// RV64 constant-load expander: descriptor queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rcle_queue #(
  parameter int DEPTH = 2
) (
  input  var logic            clk,
  input  var logic            rst_n,
  input  var logic            push_valid,
  output var logic            push_ready,
  input  var rcle_pkg::desc_t push_desc,
  output var logic            head_valid,
  output var rcle_pkg::desc_t head_desc,
  input  var logic            pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  rcle_pkg::desc_t  entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_desc  = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

### rtl/rcle_back.sv
// ----------------------------------------------------------------------------
// RV64 constant-load expander: back end
// Walks the emission mask of the head item into the output register, one
// instruction word per cycle unless stalled, and retires the item with its last word.
// ----------------------------------------------------------------------------
`default_nettype none

module rcle_back (
  input  var logic                clk,
  input  var logic                rst_n,
  input  var logic                head_valid,
  input  var rcle_pkg::desc_t     head_desc,
  output var logic                pop,
  output var logic                out_valid,
  input  var logic                out_ready,
  output var rcle_pkg::out_item_t out_item
);

  logic [rcle_pkg::NUM_SLOTS-1:0] sent_r;
  logic [rcle_pkg::NUM_SLOTS-1:0] sent_nxt;
  logic [rcle_pkg::NUM_SLOTS-1:0] remaining;
  logic [rcle_pkg::NUM_SLOTS-1:0] pick;
  logic [31:0]                    pick_word;
  logic                           pick_last;
  logic                           load;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  rcle_pkg::out_item_t            out_item_r;

  // Lowest slot still to be sent for the head item.
  assign remaining = head_desc.mask & ~sent_r;
  assign pick      = remaining & (~remaining + 1'b1);
  assign pick_last = ((remaining & ~pick) == '0);

  always_comb begin
    pick_word = '0;
    for (int i = 0; i < rcle_pkg::NUM_SLOTS; i++) begin
      pick_word = pick_word | (head_desc.words[i] & {32{pick[i]}});
    end
  end

  // Output register loads when a head item waits and the register is empty or being drained.
  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop  = load && pick_last;

  always_comb begin
    sent_nxt      = sent_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      sent_nxt      = pick_last ? '0 : (sent_r | pick);
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r.insn_word <= pick_word;
      out_item_r.last      <= pick_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

### rtl/riscv_constant_load_expander_top.sv
// ----------------------------------------------------------------------------
// RV64 constant-load expander: top level
// Turns a 64-bit constant and a destination register into the RV64
// lui/addi/slli instruction sequence that loads it.
// ----------------------------------------------------------------------------
// Each input item produces one to eight instruction words, one per result
// item, with last set on the final word (1 or 2 on the short path, 2 to 8
// on the long path). The result port delivers one word per cycle while
// out_ready is high, and the words of the next item follow without a gap
// when that item is already in the queue. An accepted item is first written
// into the queue and its first word is then loaded from the queue head into
// the output register. A queue of QUEUE_DEPTH classified items sits between
// the classifying front end and the word sequencer, so input items keep
// being taken while earlier words are still waiting to be read.
`default_nettype none

module riscv_constant_load_expander_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  var logic                clk,
  input  var logic                rst_n,
  input  var logic                in_valid,
  output var logic                in_ready,
  input  var rcle_pkg::in_item_t  in_item,
  output var logic                out_valid,
  input  var logic                out_ready,
  output var rcle_pkg::out_item_t out_item
);

  rcle_pkg::desc_t front_desc;
  rcle_pkg::desc_t head_desc;
  logic            head_valid;
  logic            pop;

  // Classification and encoding of the incoming item.
  rcle_front u_front (
    .in_item (in_item),
    .desc    (front_desc)
  );

  // Decoupling queue between front and back.
  rcle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_desc  (front_desc),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop)
  );

  // Word sequencer and output register.
  rcle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

### rtl/rcle_checker.sv
// ----------------------------------------------------------------------------
// RV64 constant-load expander: port checker
// Watches the top-level ports and checks output hold, reset behavior, the
// bound on words per item and that every last word belongs to an item.
// ----------------------------------------------------------------------------
`default_nettype none

module rcle_checker (
  input var logic                clk,
  input var logic                rst_n,
  input var logic                in_valid,
  input var logic                in_ready,
  input var logic                out_valid,
  input var logic                out_ready,
  input var rcle_pkg::out_item_t out_item
);

  logic       in_acc;
  logic       out_acc;
  logic       out_last_acc;
  logic [3:0] words_r;
  logic [3:0] words_nxt;
  logic [3:0] pending_r;
  logic [3:0] pending_nxt;

  assign in_acc       = in_valid && in_ready;
  assign out_acc      = out_valid && out_ready;
  assign out_last_acc = out_acc && out_item.last;

  // Words sent so far for the current item, and items not yet finished.
  always_comb begin
    words_nxt   = words_r;
    pending_nxt = pending_r;
    if (out_acc) begin
      words_nxt = out_item.last ? 4'd0 : words_r + 4'd1;
    end
    if (in_acc && !out_last_acc) begin
      pending_nxt = pending_r + 4'd1;
    end else if (out_last_acc && !in_acc) begin
      pending_nxt = pending_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r   <= '0;
      pending_r <= '0;
    end else begin
      words_r   <= words_nxt;
      pending_r <= pending_nxt;
    end
  end

  // A stalled result holds its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid directly after reset");

  // No item produces more than eight words.
  a_word_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> words_r < 4'd8)
    else $error("more than eight words for one item");

  // Every word belongs to an accepted, unfinished item.
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pending_r != 4'd0)
    else $error("result item without an accepted input item");

endmodule

bind riscv_constant_load_expander_top rcle_checker u_rcle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the RV64 constant-load expander
// Sends 64-bit constants with destination registers, predicts the
// lui/addi/slli word sequence for each one, and compares every received
// word and its last flag in order. The run covers edge constants first, then
// random constants under varying idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int HOLD_OFF_AFTER = 60;
  localparam int NUM_EDGE = 23;

  // Constants around the path boundaries and the piece layout of the low half.
  localparam logic [63:0] EDGE_VALUES[NUM_EDGE] = '{
    64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_07FF,
    64'h0000_0000_0000_0800, 64'h0000_0000_0000_1000, 64'h0000_0000_0000_0FFF,
    64'h0000_0000_7FFF_F7FF, 64'h0000_0000_7FFF_F800, 64'h0000_0000_FFFF_F7FF,
    64'h0000_0000_FFFF_F800, 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_F800,
    64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_8000_0000, 64'h0000_0001_0000_0000,
    64'h0000_0001_0000_0400, 64'h0000_0001_0020_0000, 64'h0000_07FF_0000_0001,
    64'hFFFF_F800_0000_0000, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
    64'h1234_5678_9ABC_DEF0, 64'h0000_0001_0000_07FF
  };

  // Predicts instruction words per constant and checks them in arrival order.
  class load_seq_scoreboard;
    rcle_pkg::out_item_t expected_words[$];
    logic [31:0] seq[$];
    int errors;
    int unsigned piece_lsb[3] = '{21, 10, 0};
    logic [5:0] piece_width[3] = '{rcle_pkg::SH_PIECE_HI, rcle_pkg::SH_PIECE_MID,
                                   rcle_pkg::SH_PIECE_LO};

    function logic [31:0] addi_word(logic [4:0] rd, logic [4:0] rs1, logic [11:0] imm);
      return rcle_pkg::OPC_ADDI | {imm, rs1, 3'b000, rd, 7'b0};
    endfunction

    function logic [31:0] slli_word(logic [4:0] rd, logic [5:0] sh);
      return rcle_pkg::OPC_SLLI | {6'b0, sh, rd, 3'b000, rd, 7'b0};
    endfunction

    // A 32-bit quantity from its rounded upper part and low 12 bits.
    function void push_hi_lo(logic [4:0] rd, logic [19:0] hi, logic [11:0] lo);
      if (hi != '0) begin
        seq.push_back(rcle_pkg::OPC_LUI | {hi, rd, 7'b0});
        if (lo != '0) seq.push_back(addi_word(rd, rd, lo));
      end else begin
        seq.push_back(addi_word(rd, 5'd0, lo));
      end
    endfunction

    function void note_input(rcle_pkg::in_item_t it);
      logic [63:0] biased;
      logic [31:0] upper_rounded;
      logic [31:0] lower;
      logic [31:0] piece;
      logic [5:0] carried_shift;
      logic [4:0] rd;
      rcle_pkg::out_item_t word;
      int k;
      rd = it.dest_reg;
      biased = it.value + 64'h800;
      seq.delete();
      if (biased[63:31] == '0) begin
        push_hi_lo(rd, biased[31:12], it.value[11:0]);
      end else begin
        // Upper half first, then the low half in three shifted pieces.
        upper_rounded = it.value[63:32] + 32'h800;
        push_hi_lo(rd, upper_rounded[31:12], it.value[43:32]);
        lower = it.value[31:0];
        carried_shift = '0;
        for (k = 0; k < 3; k++) begin
          piece = lower >> piece_lsb[k];
          carried_shift += piece_width[k];
          if (piece != '0) begin
            piece &= (32'd1 << piece_width[k]) - 32'd1;
            seq.push_back(slli_word(rd, carried_shift));
            seq.push_back(addi_word(rd, rd, piece[11:0]));
            carried_shift = '0;
          end
        end
        if (carried_shift != '0) seq.push_back(slli_word(rd, carried_shift));
      end
      foreach (seq[i]) begin
        word.insn_word = seq[i];
        word.last = (i == seq.size() - 1);
        expected_words.push_back(word);
      end
    endfunction

    function void check_result(rcle_pkg::out_item_t got);
      rcle_pkg::out_item_t want;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: expected none, got word %h last %b",
                 $time, got.insn_word, got.last);
        return;
      end
      want = expected_words.pop_front();
      if (got.insn_word !== want.insn_word) begin
        errors++;
        $display("%0t: insn_word: expected %h, got %h", $time, want.insn_word, got.insn_word);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last: expected %b, got %b (word %h)", $time, want.last, got.last,
                 want.insn_word);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rcle_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rcle_pkg::out_item_t out_item;

  load_seq_scoreboard sb = new();
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int accepted_items = 0;

  riscv_constant_load_expander_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps with an occasional long one.
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random constants weighted toward the interesting regions of both paths.
  function automatic logic [63:0] random_constant();
    logic [63:0] v;
    logic [31:0] half;
    v = {$urandom, $urandom};
    half = $urandom;
    case ($urandom_range(0, 8))
      1: v = 64'($urandom_range(0, 32'h7FFF_F7FF));
      2: v = 64'($urandom_range(0, 4095));
      3: v = 64'h7FFF_F7F8 + 64'($urandom_range(0, 15));
      4: v = -64'($urandom_range(0, 8192));
      5: begin
        // Drop random pieces of the low half.
        if ($urandom_range(0, 1) == 1) v[31:21] = '0;
        if ($urandom_range(0, 1) == 1) v[20:10] = '0;
        if ($urandom_range(0, 1) == 1) v[9:0] = '0;
      end
      6: begin
        // Upper half near the rounding edges of its own lui/addi pair.
        case ($urandom_range(0, 2))
          0: v[63:32] = 32'($urandom_range(0, 4095));
          1: v[63:32] = 32'hFFFF_F7F8 + 32'($urandom_range(0, 15));
          default: v[43:32] = $urandom_range(0, 1) ? 12'h7FF : 12'h800;
        endcase
      end
      7: v = {32'h0, half};
      8: v = {{32{half[31]}}, half};
      default: ;
    endcase
    return v;
  endfunction

  // Offers one item and holds it until accepted, then maybe idles.
  task automatic offer_item(input logic [63:0] value, input logic [4:0] rd);
    rcle_pkg::in_item_t it;
    it.value = value;
    it.dest_reg = rd;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  task automatic random_phase(input int count, input int gap_pct, input int stall_pct);
    tx_gap_pct = gap_pct;
    rx_stall_pct = stall_pct;
    repeat (count) offer_item(random_constant(), 5'($urandom_range(0, 31)));
  endtask

  // Both handshakes are sampled here, before any update of this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_input(in_item);
        accepted_items++;
      end
      if (out_valid && out_ready) sb.check_result(out_item);
    end
  end

  // Result side: random stalls, plus one long hold-off to fill the block.
  initial begin : receiver
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!hold_done && accepted_items >= HOLD_OFF_AFTER) begin
          stall_left = HOLD_OFF_CYCLES;
          hold_done = 1'b1;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
          stall_left = idle_len();
        end
      end
    end
  end

  // Ends the run when nothing moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("riscv_constant_load_expander_top: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int i;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Edge constants, cycling through x0, x31 and a random register.
    tx_gap_pct = 30;
    rx_stall_pct = 30;
    for (i = 0; i < NUM_EDGE; i++) begin
      case (i % 3)
        0: offer_item(EDGE_VALUES[i], 5'd0);
        1: offer_item(EDGE_VALUES[i], 5'd31);
        default: offer_item(EDGE_VALUES[i], 5'($urandom_range(0, 31)));
      endcase
    end

    // No idling at first (the long hold-off lands here), then mixed idling.
    random_phase(120, 0, 0);
    random_phase(120, 40, 40);
    random_phase(110, 15, 60);
    in_valid <= 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("riscv_constant_load_expander_top: match");
    end else begin
      $display("riscv_constant_load_expander_top: mismatch");
    end
    $finish;
  end

endmodule
